// ===== rtl/wfm_pkg.sv =====
// Shared constants, mode codes and stage tag type for the weight falloff mapper.
package wfm_pkg;

  localparam int WEIGHT_W      = 17;
  localparam int MODE_W        = 3;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_SHARP  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SMOOTH = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROOT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SPHERE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STEP   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PASS   = 3'd5;

  typedef struct packed {
    logic                is_last;
    logic                use_root;
    logic [WEIGHT_W-1:0] value;
  } wfm_tag_t;

endpackage

// ===== rtl/wfm_in_if.sv =====
// Input word channel of the weight falloff mapper.
interface wfm_in_if;
  logic                         valid;
  logic                         ready;
  logic [wfm_pkg::WEIGHT_W-1:0] weight_in;
  logic                         is_last_in;

  modport source (output valid, weight_in, is_last_in, input ready);
  modport sink   (input valid, weight_in, is_last_in, output ready);
endinterface

// ===== rtl/wfm_out_if.sv =====
// Output word channel of the weight falloff mapper.
interface wfm_out_if;
  logic                         valid;
  logic                         ready;
  logic [wfm_pkg::WEIGHT_W-1:0] weight_out;
  logic                         is_last_out;

  modport source (output valid, weight_out, is_last_out, input ready);
  modport sink   (input valid, weight_out, is_last_out, output ready);
endinterface

// ===== rtl/weight_falloff_mapper.sv =====
// Top level of the weight falloff mapper: saturation, products, square root and output stage.
//
// Each word is mapped through the curve selected by the mode register (sharp, smooth,
// root, sphere, step or pass-through) and passes through stage A, stage B, stage C,
// the square root digit stages and the output stage before it leaves the block. The
// square root takes one result bit per stage, so its digit count sets the depth. One
// word enters and one leaves in every cycle while the output is not stalled; every
// stage holds its word while the one after it is full, and bubbles close up, so a
// stalled output keeps taking words until the pipeline is full. The mode is sampled
// as a word enters, and the batch-end marker travels with it.
module weight_falloff_mapper #(
  parameter int FRAC_BITS = wfm_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [wfm_pkg::MODE_W-1:0] cfg_wdata_i,
  wfm_in_if.sink                     in_i,
  wfm_out_if.source                  out_o
);

  localparam int WW = wfm_pkg::WEIGHT_W;
  localparam int CW = ((FRAC_BITS + 1 > WW) ? FRAC_BITS + 1 : WW) + 1;
  localparam int KW = (FRAC_BITS + 3 > WW + 2) ? FRAC_BITS + 3 : WW + 2;
  localparam int PW = WW + KW;
  localparam int RW = WW + FRAC_BITS + 1;
  localparam int XW = (RW > 2 * WW) ? RW : 2 * WW;
  localparam int NB = (RW + 1) / 2;
  localparam int NS = NB + 4;
  localparam int OW = $clog2(NS + 1);

  localparam logic [CW-1:0] OneC  = CW'(1) << FRAC_BITS;
  localparam logic [CW-1:0] HalfC = OneC >> 1;
  localparam logic [KW-1:0] OneK  = KW'(1) << FRAC_BITS;
  localparam logic [KW-1:0] OneK3 = (OneK << 1) + OneK;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  logic [wfm_pkg::MODE_W-1:0] mode_q;

  // Stage A: saturated weight.
  logic                       a_v_q;
  logic [WW-1:0]              a_raw_q;
  logic [WW-1:0]              a_f_q;
  logic [wfm_pkg::MODE_W-1:0] a_mode_q;
  logic                       a_last_q;
  logic [WW-1:0]              f_d;

  // Stage B: square of the weight.
  logic                       b_v_q;
  logic [WW-1:0]              b_raw_q;
  logic [WW-1:0]              b_f_q;
  logic [wfm_pkg::MODE_W-1:0] b_mode_q;
  logic                       b_last_q;
  logic [2*WW-1:0]            b_ff_q;
  logic [2*WW-1:0]            ff_d;

  // Stage C: curve value and square root radicand.
  logic                       c_v_q;
  wfm_pkg::wfm_tag_t          c_tag_q;
  logic [RW-1:0]              c_rad_q;
  wfm_pkg::wfm_tag_t          tag_d;
  logic [RW-1:0]              rad_d;
  logic [2*WW-1:0]            sq_x;
  logic [WW-1:0]              sq;
  logic [KW-1:0]              kfac;
  logic [PW-1:0]              prod;
  logic [PW-1:0]              smooth_x;
  logic [XW-1:0]              f_x;
  logic [XW-1:0]              ff_x;
  logic [XW-1:0]              rad_x;
  logic                       step_hi;

  logic              sq_v    [0:NB];
  wfm_pkg::wfm_tag_t sq_tag  [0:NB];
  logic [RW-1:0]     sq_rem  [0:NB];
  logic [RW-1:0]     sq_root [0:NB];

  logic          out_v_q;
  logic [WW-1:0] out_w_q;
  logic          out_last_q;

  logic [OW-1:0] occ_q;

  // A stage takes a new word when it is empty or the stage after it moves on.
  assign rdy[NS] = out_o.ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign in_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= wfm_pkg::MODE_PASS;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign f_d = (CW'(in_i.weight_in) > OneC) ? OneC[WW-1:0] : in_i.weight_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (rdy[0]) a_v_q <= in_i.valid;
      if (rdy[1]) b_v_q <= a_v_q;
      if (rdy[2]) c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      a_raw_q  <= in_i.weight_in;
      a_f_q    <= f_d;
      a_mode_q <= mode_q;
      a_last_q <= in_i.is_last_in;
    end
    if (rdy[1]) begin
      b_raw_q  <= a_raw_q;
      b_f_q    <= a_f_q;
      b_mode_q <= a_mode_q;
      b_last_q <= a_last_q;
      b_ff_q   <= ff_d;
    end
    if (rdy[2]) begin
      c_tag_q <= tag_d;
      c_rad_q <= rad_d;
    end
  end

  assign ff_d = (2 * WW)'(a_f_q) * (2 * WW)'(a_f_q);

  always_comb begin
    sq_x     = b_ff_q >> FRAC_BITS;
    sq       = sq_x[WW-1:0];
    kfac     = OneK3 - (KW'(b_f_q) << 1);
    prod     = PW'(sq) * PW'(kfac);
    smooth_x = prod >> FRAC_BITS;
    step_hi  = (CW'(b_f_q) >= HalfC);
    f_x      = XW'(b_f_q);
    ff_x     = XW'(b_ff_q);
    if (b_mode_q == wfm_pkg::MODE_SPHERE) begin
      rad_x = (f_x << (FRAC_BITS + 1)) - ff_x;
    end else begin
      rad_x = f_x << FRAC_BITS;
    end
    rad_d = rad_x[RW-1:0];

    tag_d.is_last  = b_last_q;
    tag_d.use_root = 1'b0;
    unique case (b_mode_q)
      wfm_pkg::MODE_SHARP:  tag_d.value = sq;
      wfm_pkg::MODE_SMOOTH: tag_d.value = smooth_x[WW-1:0];
      wfm_pkg::MODE_ROOT, wfm_pkg::MODE_SPHERE: begin
        tag_d.value    = '0;
        tag_d.use_root = 1'b1;
      end
      wfm_pkg::MODE_STEP:   tag_d.value = step_hi ? OneC[WW-1:0] : '0;
      default:              tag_d.value = b_raw_q;
    endcase
  end

  assign vld[0] = a_v_q;
  assign vld[1] = b_v_q;
  assign vld[2] = c_v_q;

  assign sq_v[0]    = c_v_q;
  assign sq_tag[0]  = c_tag_q;
  assign sq_rem[0]  = c_rad_q;
  assign sq_root[0] = '0;

  for (genvar j = 0; j < NB; j++) begin : g_sqrt
    wfm_sqrt_step #(
      .RAD_W   (RW),
      .BIT_POS (2 * (NB - 1 - j))
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (rdy[3+j]),
      .valid_i (sq_v[j]),
      .tag_i   (sq_tag[j]),
      .rem_i   (sq_rem[j]),
      .root_i  (sq_root[j]),
      .valid_o (sq_v[j+1]),
      .tag_o   (sq_tag[j+1]),
      .rem_o   (sq_rem[j+1]),
      .root_o  (sq_root[j+1])
    );
    assign vld[3+j] = sq_v[j+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy[NS-1]) begin
      out_v_q <= sq_v[NB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      out_w_q    <= sq_tag[NB].use_root ? sq_root[NB][WW-1:0] : sq_tag[NB].value;
      out_last_q <= sq_tag[NB].is_last;
    end
  end

  assign vld[NS-1]         = out_v_q;
  assign out_o.valid       = out_v_q;
  assign out_o.weight_out  = out_w_q;
  assign out_o.is_last_out = out_last_q;

  // Words in flight, kept only to cross-check the stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + OW'(in_i.valid && in_i.ready) - OW'(out_o.valid && out_o.ready);
    end
  end

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == OW'($countones(vld)))
    else $error("word count does not match the stage valid bits");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_v_q |-> in_i.ready)
    else $error("input stalled while the output stage is empty");

  a_root_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_v[NB] && sq_tag[NB].use_root) |-> (sq_rem[NB] <= (sq_root[NB] << 1)))
    else $error("square root remainder out of range");

endmodule

// ===== rtl/wfm_sqrt_step.sv =====
// One registered digit step of the pipelined integer square root.
module wfm_sqrt_step #(
  parameter int RAD_W   = 34,
  parameter int BIT_POS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  wfm_pkg::wfm_tag_t tag_i,
  input  logic [RAD_W-1:0]  rem_i,
  input  logic [RAD_W-1:0]  root_i,
  output logic              valid_o,
  output wfm_pkg::wfm_tag_t tag_o,
  output logic [RAD_W-1:0]  rem_o,
  output logic [RAD_W-1:0]  root_o
);

  localparam logic [RAD_W-1:0] BitVal = RAD_W'(1) << BIT_POS;

  logic [RAD_W-1:0] trial;
  logic             take;
  logic [RAD_W-1:0] rem_d;
  logic [RAD_W-1:0] root_d;
  logic             valid_q;
  wfm_pkg::wfm_tag_t tag_q;
  logic [RAD_W-1:0] rem_q;
  logic [RAD_W-1:0] root_q;

  always_comb begin
    trial = root_i + BitVal;
    take  = (rem_i >= trial);
    if (take) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + BitVal;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q  <= tag_i;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule
